// ===== hdl/rau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned DW = 64;

    localparam logic [2:0] MODE_NORM  = 3'd0;
    localparam logic [2:0] MODE_ADD   = 3'd1;
    localparam logic [2:0] MODE_SUB   = 3'd2;
    localparam logic [2:0] MODE_MUL   = 3'd3;
    localparam logic [2:0] MODE_DIV   = 3'd4;
    localparam logic [2:0] MODE_RECIP = 3'd5;
    localparam logic [2:0] MODE_CMP   = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic          neg;
        logic [31:0]   mag;
    } t_sm32;

    typedef struct packed {
        logic          neg;
        logic [DW-1:0] mag;
    } t_sm64;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_GCD,
        S_GCD_WAIT,
        S_QN_GO,
        S_QN_WAIT,
        S_QD_GO,
        S_QD_WAIT,
        S_CHECK,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/rau_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rau_pkg::t_div_req i_req,
    output rau_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned CW = $clog2(rau_pkg::DW + 1);

    logic                     r_busy, n_busy;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [rau_pkg::DW-1:0]   r_rem, n_rem;
    logic [rau_pkg::DW-1:0]   r_quot, n_quot;
    logic [rau_pkg::DW-1:0]   r_dvs, n_dvs;
    logic [rau_pkg::DW:0]     rem_sh;
    logic [rau_pkg::DW:0]     diff;

    assign rem_sh = {r_rem, r_quot[rau_pkg::DW-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(rau_pkg::DW);
            n_rem  = '0;
            n_quot = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
                if (!diff[rau_pkg::DW]) begin
                    n_rem  = diff[rau_pkg::DW-1:0];
                    n_quot = {r_quot[rau_pkg::DW-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[rau_pkg::DW-1:0];
                    n_quot = {r_quot[rau_pkg::DW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

// ===== hdl/rational_arith_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arith_unit
// signed fraction arithmetic with gcd reduction on a shared divider
// ----------------------------------------------------------------------------
// channel   direction  handshake
// command   in         start, busy (word taken when start high, busy low)
// result    out        o_res_valid strobe, one cycle, no back-pressure
//
// a zero denominator goes straight from idle to the result strobe; compare
// ends after its products and the combine step; the other modes then reduce
// a nonzero result: one 32x32 multiply per product cycle, then each euclid step
// and the two final divisions run on the shared 64-bit restoring divider
// busy stays high through the result strobe cycle; synchronous active-low reset
// ----------------------------------------------------------------------------
module rational_arith_unit #(
    parameter int unsigned FIELD_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [31:0] i_left_num,
    input  wire logic [31:0] i_left_den,
    input  wire logic [31:0] i_right_num,
    input  wire logic [31:0] i_right_den,
    output logic             o_res_valid,
    output logic [31:0]      o_res_num,
    output logic [30:0]      o_res_den,
    output logic             o_less_flag,
    output logic             o_equal_flag,
    output logic [1:0]       o_status
);

    localparam logic [63:0] LIMIT = 64'd1 << (FIELD_WIDTH - 1);

    rau_pkg::t_state   r_state, n_state;
    logic [2:0]        r_mode;
    rau_pkg::t_sm32    r_ln, r_ld, r_rn, r_rd;
    rau_pkg::t_sm64    r_p0, r_p1, r_p2;
    rau_pkg::t_sm64    r_num, r_den;
    logic [63:0]       r_a, r_b;
    logic [31:0]       r_res_num;
    logic [30:0]       r_res_den;
    logic              r_lt, r_eq;
    logic [1:0]        r_st;

    rau_pkg::t_sm32    op_a, op_b;
    rau_pkg::t_sm32    rn_sm;
    rau_pkg::t_sm64    prod;
    rau_pkg::t_sm64    sum;
    rau_pkg::t_div_req div_req;
    rau_pkg::t_div_rsp div_rsp;
    logic [2:0]        in_mode;
    logic              in_zero;
    logic signed [63:0] cmp_x, cmp_y;
    logic              res_neg;

    function automatic rau_pkg::t_sm32 to_sm(input logic [31:0] v);
        rau_pkg::t_sm32 s;
        s.neg = v[31];
        s.mag = v[31] ? (~v + 32'd1) : v;
        return s;
    endfunction

    assign in_mode = (i_mode == 3'd7) ? rau_pkg::MODE_NORM : i_mode;
    assign in_zero = (i_left_den == '0) ||
                     (in_mode != rau_pkg::MODE_NORM && in_mode != rau_pkg::MODE_RECIP &&
                      i_right_den == '0);
    assign rn_sm   = to_sm(i_right_num);

    // multiplier operand select
    always_comb begin
        op_a = r_ln;
        op_b = '{neg: 1'b0, mag: 32'd1};
        case (r_state)
            rau_pkg::S_MUL0: begin
                case (r_mode) inside
                    rau_pkg::MODE_ADD, rau_pkg::MODE_SUB, rau_pkg::MODE_DIV,
                    rau_pkg::MODE_CMP: op_b = r_rd;
                    rau_pkg::MODE_MUL: op_b = r_rn;
                    rau_pkg::MODE_RECIP: op_a = r_ld;
                    default: op_a = r_ln;
                endcase
            end
            rau_pkg::S_MUL1: begin
                op_a = r_ld;
                case (r_mode) inside
                    rau_pkg::MODE_ADD, rau_pkg::MODE_SUB, rau_pkg::MODE_MUL: op_b = r_rd;
                    rau_pkg::MODE_DIV, rau_pkg::MODE_CMP: op_b = r_rn;
                    rau_pkg::MODE_RECIP: op_a = r_ln;
                    default: op_a = r_ld;
                endcase
            end
            default: begin
                op_a = r_rn;
                op_b = r_ld;
            end
        endcase
    end

    assign prod.neg = op_a.neg ^ op_b.neg;
    assign prod.mag = {32'd0, op_a.mag} * {32'd0, op_b.mag};

    always_comb begin
        if (r_p0.neg == r_p2.neg) begin
            sum.neg = r_p0.neg;
            sum.mag = r_p0.mag + r_p2.mag;
        end else if (r_p0.mag >= r_p2.mag) begin
            sum.neg = r_p0.neg;
            sum.mag = r_p0.mag - r_p2.mag;
        end else begin
            sum.neg = r_p2.neg;
            sum.mag = r_p2.mag - r_p0.mag;
        end
    end

    assign cmp_x   = r_p0.neg ? -$signed(r_p0.mag) : $signed(r_p0.mag);
    assign cmp_y   = r_p1.neg ? -$signed(r_p1.mag) : $signed(r_p1.mag);
    assign res_neg = r_num.neg ^ r_den.neg;

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rau_pkg::S_IDLE:     if (start) n_state = in_zero ? rau_pkg::S_DONE
                                                              : rau_pkg::S_MUL0;
            rau_pkg::S_MUL0:     n_state = rau_pkg::S_MUL1;
            rau_pkg::S_MUL1:     n_state = (r_mode == rau_pkg::MODE_ADD ||
                                            r_mode == rau_pkg::MODE_SUB)
                                           ? rau_pkg::S_MUL2 : rau_pkg::S_COMB;
            rau_pkg::S_MUL2:     n_state = rau_pkg::S_COMB;
            rau_pkg::S_COMB: begin
                if (r_mode == rau_pkg::MODE_CMP || r_p1.mag == '0 ||
                    ((r_mode == rau_pkg::MODE_ADD || r_mode == rau_pkg::MODE_SUB)
                     ? (sum.mag == '0) : (r_p0.mag == '0))) begin
                    n_state = rau_pkg::S_DONE;
                end else begin
                    n_state = rau_pkg::S_GCD;
                end
            end
            rau_pkg::S_GCD:      n_state = (r_b == '0) ? rau_pkg::S_QN_GO
                                                       : rau_pkg::S_GCD_WAIT;
            rau_pkg::S_GCD_WAIT: if (div_rsp.done) n_state = rau_pkg::S_GCD;
            rau_pkg::S_QN_GO:    n_state = rau_pkg::S_QN_WAIT;
            rau_pkg::S_QN_WAIT:  if (div_rsp.done) n_state = rau_pkg::S_QD_GO;
            rau_pkg::S_QD_GO:    n_state = rau_pkg::S_QD_WAIT;
            rau_pkg::S_QD_WAIT:  if (div_rsp.done) n_state = rau_pkg::S_CHECK;
            rau_pkg::S_CHECK:    n_state = rau_pkg::S_DONE;
            rau_pkg::S_DONE:     n_state = rau_pkg::S_IDLE;
            default:             n_state = rau_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        busy         = 1'b1;
        o_res_valid  = 1'b0;
        div_req      = '{start: 1'b0, dividend: r_a, divisor: r_b};
        unique case (r_state)
            rau_pkg::S_IDLE:  busy = 1'b0;
            rau_pkg::S_GCD:   div_req.start = (r_b != '0);
            rau_pkg::S_QN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_num.mag;
                div_req.divisor  = r_a;
            end
            rau_pkg::S_QD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_den.mag;
                div_req.divisor  = r_a;
            end
            rau_pkg::S_DONE:  o_res_valid = 1'b1;
            default:          busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::S_IDLE: begin
                r_mode <= in_mode;
                r_ln   <= to_sm(i_left_num);
                r_ld   <= to_sm(i_left_den);
                r_rn   <= '{neg: rn_sm.neg ^ (in_mode == rau_pkg::MODE_SUB),
                            mag: rn_sm.mag};
                r_rd   <= to_sm(i_right_den);
                r_res_num <= '0;
                r_res_den <= '0;
                r_lt      <= 1'b0;
                r_eq      <= 1'b0;
                r_st      <= rau_pkg::ST_ZERO;
            end
            rau_pkg::S_MUL0: r_p0 <= prod;
            rau_pkg::S_MUL1: r_p1 <= prod;
            rau_pkg::S_MUL2: r_p2 <= prod;
            rau_pkg::S_COMB: begin
                r_num <= (r_mode == rau_pkg::MODE_ADD || r_mode == rau_pkg::MODE_SUB)
                         ? sum : r_p0;
                r_den <= r_p1;
                r_a   <= r_p1.mag;
                r_b   <= (r_mode == rau_pkg::MODE_ADD || r_mode == rau_pkg::MODE_SUB)
                         ? sum.mag : r_p0.mag;
                if (r_mode == rau_pkg::MODE_CMP) begin
                    r_st      <= rau_pkg::ST_OK;
                    r_res_den <= 31'd1;
                    r_eq      <= (cmp_x == cmp_y);
                    r_lt      <= (r_ld.neg ^ r_rd.neg) ? (cmp_x > cmp_y) : (cmp_x < cmp_y);
                end else if (r_p1.mag != '0) begin
                    r_st      <= rau_pkg::ST_OK;
                    r_res_den <= 31'd1;
                end
            end
            rau_pkg::S_GCD_WAIT: begin
                if (div_rsp.done) begin
                    r_a <= r_b;
                    r_b <= div_rsp.rem;
                end
            end
            rau_pkg::S_QN_WAIT: if (div_rsp.done) r_num.mag <= div_rsp.quot;
            rau_pkg::S_QD_WAIT: if (div_rsp.done) r_den.mag <= div_rsp.quot;
            rau_pkg::S_CHECK: begin
                if (r_den.mag > LIMIT - 64'd1 ||
                    r_num.mag > (res_neg ? LIMIT : LIMIT - 64'd1)) begin
                    r_st      <= rau_pkg::ST_OVF;
                    r_res_num <= '0;
                    r_res_den <= '0;
                end else begin
                    r_st      <= rau_pkg::ST_OK;
                    r_res_num <= res_neg ? (~r_num.mag[31:0] + 32'd1) : r_num.mag[31:0];
                    r_res_den <= r_den.mag[30:0];
                end
            end
            default: r_mode <= r_mode;
        endcase
    end

    assign o_res_num    = r_res_num;
    assign o_res_den    = r_res_den;
    assign o_less_flag  = r_lt;
    assign o_equal_flag = r_eq;
    assign o_status     = r_st;

endmodule
`default_nettype wire
